### design/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg - shared types and constants of the timer event multiplexer
// Table size, field widths, status codes and the structs between the
// sequencer, the slot memory and the scan unit.
// ----------------------------------------------------------------------------
package tem_pkg;

    localparam int SLOTS      = 32;
    localparam int FIRE_LIMIT = 32;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int FIRE_W     = $clog2(FIRE_LIMIT + 1);

    localparam int TIME_W = 64;
    localparam int ORD_W  = 64;
    localparam int TAG_W  = 16;
    localparam int FREQ_W = 32;
    localparam int SEC_W  = 32;

    // input item kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOFREQ = 2'd2;
    localparam logic [1:0] ST_FIRED  = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ORD_W-1:0]  order;
        logic [TAG_W-1:0]  tag;
    } t_slot;

    typedef struct packed {
        logic              clear;    // start of a pass, drop accumulated picks
        logic              en;       // a valid slot is presented this cycle
        logic              use_due;  // track the earliest expired slot
        logic [TIME_W-1:0] now;
    } t_scan_ctl;

    typedef struct packed {
        logic              due_found;
        logic [IDX_W-1:0]  due_idx;
        logic [TAG_W-1:0]  due_tag;
        logic              any_found;
        logic [TIME_W-1:0] min_deadline;
    } t_scan_res;

endpackage

### design/tem_slot_mem.sv
// ----------------------------------------------------------------------------
// tem_slot_mem - event slot storage
// Deadline, order and tag of each slot; one write port, one registered read.
// ----------------------------------------------------------------------------
module tem_slot_mem (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [tem_pkg::IDX_W-1:0] i_wr_idx,
    input  tem_pkg::t_slot            i_wr_data,
    input  logic                      i_rd_en,
    input  logic [tem_pkg::IDX_W-1:0] i_rd_idx,
    output tem_pkg::t_slot            o_rd_data
);

    tem_pkg::t_slot r_mem [tem_pkg::SLOTS];
    tem_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/tem_scan_unit.sv
// ----------------------------------------------------------------------------
// tem_scan_unit - shared compare unit
// Takes one slot per cycle and keeps the earliest expired slot (deadline,
// then order) and the smallest deadline over all presented slots.
// ----------------------------------------------------------------------------
module tem_scan_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tem_pkg::t_scan_ctl        i_ctl,
    input  logic [tem_pkg::IDX_W-1:0] i_idx,
    input  tem_pkg::t_slot            i_slot,
    output tem_pkg::t_scan_res        o_res
);

    logic                       r_due_found;
    logic [tem_pkg::IDX_W-1:0]  r_due_idx;
    logic [tem_pkg::TAG_W-1:0]  r_due_tag;
    logic [tem_pkg::TIME_W-1:0] r_due_dl;
    logic [tem_pkg::ORD_W-1:0]  r_due_ord;
    logic                       r_any;
    logic [tem_pkg::TIME_W-1:0] r_min;

    logic is_due;
    logic beats_due;
    logic beats_min;

    assign is_due    = i_ctl.use_due && (i_slot.deadline <= i_ctl.now);
    assign beats_due = !r_due_found || (i_slot.deadline < r_due_dl) ||
                       ((i_slot.deadline == r_due_dl) && (i_slot.order < r_due_ord));
    assign beats_min = !r_any || (i_slot.deadline < r_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_due_found <= 1'b0;
            r_any       <= 1'b0;
        end else if (i_ctl.clear) begin
            r_due_found <= 1'b0;
            r_any       <= 1'b0;
        end else if (i_ctl.en) begin
            if (is_due && beats_due) begin
                r_due_found <= 1'b1;
            end
            r_any <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && !i_ctl.clear) begin
            if (is_due && beats_due) begin
                r_due_idx <= i_idx;
                r_due_tag <= i_slot.tag;
                r_due_dl  <= i_slot.deadline;
                r_due_ord <= i_slot.order;
            end
            if (beats_min) begin
                r_min <= i_slot.deadline;
            end
        end
    end

    assign o_res.due_found    = r_due_found;
    assign o_res.due_idx      = r_due_idx;
    assign o_res.due_tag      = r_due_tag;
    assign o_res.any_found    = r_any;
    assign o_res.min_deadline = r_min;

endmodule

### design/timer_event_multiplexer.sv
// ----------------------------------------------------------------------------
// timer_event_multiplexer - pending timer table with earliest-deadline firing
// Stores add items as events and fires expired events on tick items.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*): one item per add or tick; tuser is the kind.
//   Master channel (o_m_*): results; tlast marks the summary that closes an
//   item, fired events come before it, earliest deadline first, ties oldest.
//   Config channel (i_cfg_*): ticks_per_second, write only while idle.
//   One item at a time: o_s_tready is high only when the block is idle.
//   Every result needs one pass of the compare unit over all slots, one slot
//   per cycle, and each result then waits on i_m_tready in S_OUT.
//   An add with a frequency and a free slot first multiplies and adds
//   (S_MUL, S_ADD); a tick that fires k events makes k + 1 passes.
//   A stalled receiver holds the result in the output register and the
//   sequencer waits; nothing is dropped.
//   Reset empties the table, clears the order counter and the frequency.
// ----------------------------------------------------------------------------
module timer_event_multiplexer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data,    // ticks_per_second
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,     // cur_time[63:0], delay_seconds[95:64],
                                        // event_tag[111:96]
    input  logic         i_s_tuser,     // kind
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [87:0]  o_m_tdata,     // fired_tag[15:0], timer_armed[16],
                                        // next_deadline[80:17], zero[87:81]
    output logic [1:0]   o_m_tuser,     // status
    output logic         o_m_tlast      // last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                  r_state;
    logic [tem_pkg::FREQ_W-1:0]  r_freq;
    logic [tem_pkg::ORD_W-1:0]   r_order_cnt;
    logic [tem_pkg::SLOTS-1:0]   r_slot_valid;
    logic [tem_pkg::CNT_W-1:0]   r_scan_cnt;
    logic [tem_pkg::FIRE_W-1:0]  r_fire_cnt;
    logic                        r_more;
    logic                        r_use_due;
    logic [1:0]                  r_status;

    logic [tem_pkg::TIME_W-1:0]  r_now;
    logic [tem_pkg::SEC_W-1:0]   r_secs;
    logic [tem_pkg::TAG_W-1:0]   r_tag;
    logic [tem_pkg::IDX_W-1:0]   r_free_idx;
    logic [tem_pkg::TIME_W-1:0]  r_prod;

    logic                        r_rd_en;
    logic                        r_rd_valid;
    logic [tem_pkg::IDX_W-1:0]   r_rd_idx;

    logic [1:0]                  r_out_status;
    logic [tem_pkg::TAG_W-1:0]   r_out_tag;
    logic                        r_out_armed;
    logic [tem_pkg::TIME_W-1:0]  r_out_next;
    logic                        r_out_last;

    logic                        free_found;
    logic [tem_pkg::IDX_W-1:0]   free_idx;
    logic                        in_acc;
    logic                        rd_en;
    logic [tem_pkg::IDX_W-1:0]   rd_idx;
    logic                        wr_en;
    tem_pkg::t_slot              wr_data;
    tem_pkg::t_slot              rd_data;
    tem_pkg::t_scan_ctl          scan_ctl;
    tem_pkg::t_scan_res          scan_res;
    logic                        fire;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = tem_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                free_found = 1'b1;
                free_idx   = tem_pkg::IDX_W'(i);
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;

    assign rd_en  = (r_state == S_SCAN) && (r_scan_cnt < tem_pkg::CNT_W'(tem_pkg::SLOTS));
    assign rd_idx = r_scan_cnt[tem_pkg::IDX_W-1:0];

    assign wr_en            = (r_state == S_ADD);
    assign wr_data.deadline = r_now + r_prod;
    assign wr_data.order    = r_order_cnt;
    assign wr_data.tag      = r_tag;

    assign scan_ctl.clear   = (r_state == S_SCAN) && (r_scan_cnt == '0);
    assign scan_ctl.en      = r_rd_en && r_rd_valid;
    assign scan_ctl.use_due = r_use_due;
    assign scan_ctl.now     = r_now;

    assign fire = r_use_due && scan_res.due_found &&
                  (r_fire_cnt < tem_pkg::FIRE_W'(tem_pkg::FIRE_LIMIT));

    tem_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_free_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    tem_scan_unit u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_idx   (r_rd_idx),
        .i_slot  (rd_data),
        .o_res   (scan_res)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_freq       <= '0;
            r_order_cnt  <= '0;
            r_slot_valid <= '0;
            r_scan_cnt   <= '0;
            r_fire_cnt   <= '0;
            r_more       <= 1'b0;
            r_use_due    <= 1'b0;
            r_status     <= tem_pkg::ST_OK;
            r_rd_en      <= 1'b0;
        end else begin
            r_rd_en <= rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                r_freq <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    r_scan_cnt <= '0;
                    r_fire_cnt <= '0;
                    if (in_acc) begin
                        r_use_due <= (i_s_tuser == tem_pkg::KIND_TICK);
                        if (i_s_tuser == tem_pkg::KIND_TICK) begin
                            r_status <= tem_pkg::ST_OK;
                            r_state  <= S_SCAN;
                        end else if (r_freq == '0) begin
                            r_status <= tem_pkg::ST_NOFREQ;
                            r_state  <= S_SCAN;
                        end else if (!free_found) begin
                            r_status <= tem_pkg::ST_FULL;
                            r_state  <= S_SCAN;
                        end else begin
                            r_status <= tem_pkg::ST_OK;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_slot_valid[r_free_idx] <= 1'b1;
                    r_order_cnt              <= r_order_cnt + tem_pkg::ORD_W'(1);
                    r_state                  <= S_SCAN;
                end
                S_SCAN: begin
                    // last slot data is taken in on the cycle the count hits SLOTS
                    if (r_scan_cnt == tem_pkg::CNT_W'(tem_pkg::SLOTS)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_scan_cnt <= r_scan_cnt + tem_pkg::CNT_W'(1);
                    end
                end
                S_DECIDE: begin
                    r_scan_cnt <= '0;
                    r_more     <= fire;
                    if (fire) begin
                        r_slot_valid[scan_res.due_idx] <= 1'b0;
                        r_fire_cnt <= r_fire_cnt + tem_pkg::FIRE_W'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= r_more ? S_SCAN : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now      <= i_s_tdata[63:0];
            r_secs     <= i_s_tdata[95:64];
            r_tag      <= i_s_tdata[111:96];
            r_free_idx <= free_idx;
        end
        if (r_state == S_MUL) begin
            r_prod <= tem_pkg::TIME_W'(r_secs) * tem_pkg::TIME_W'(r_freq);
        end
        r_rd_valid <= r_slot_valid[rd_idx];
        r_rd_idx   <= rd_idx;
        if (r_state == S_DECIDE) begin
            if (fire) begin
                r_out_status <= tem_pkg::ST_FIRED;
                r_out_tag    <= scan_res.due_tag;
                r_out_armed  <= 1'b0;
                r_out_next   <= '0;
                r_out_last   <= 1'b0;
            end else begin
                r_out_status <= r_status;
                r_out_tag    <= '0;
                r_out_armed  <= scan_res.any_found;
                r_out_next   <= scan_res.any_found ? scan_res.min_deadline : '0;
                r_out_last   <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {7'd0, r_out_next, r_out_armed, r_out_tag};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    // one item in flight: never ready while a result is waiting
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid)
        else $error("input ready while a result is pending");

    // a fired event is never the closing result
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == tem_pkg::ST_FIRED)) |-> !o_m_tlast)
        else $error("fired result marked last");

    // an unarmed summary reports a zero deadline
    a_unarmed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast && !o_m_tdata[16]) |-> (o_m_tdata[80:17] == '0))
        else $error("unarmed summary with nonzero deadline");

    // firing never exceeds the per-tick limit
    a_fire_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> (r_fire_cnt <= tem_pkg::FIRE_W'(tem_pkg::FIRE_LIMIT)))
        else $error("fire count beyond limit");

endmodule
